// File: hw/rtl/pcwh_pkg.sv
// ----------------------------------------------------------------------------
// pcwh_pkg: shared constants and types for the window height block
// Point store sizing, op codes and field widths.
// ----------------------------------------------------------------------------
package pcwh_pkg;
    localparam int MAX_POINTS = 4096;
    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int DW = 24;
    // one memory word: x, y, height, height valid
    localparam int MW = 3 * DW + 1;
    localparam int SW = DW + CW;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic signed [SW-1:0] sum;
        logic [CW-1:0]        cnt;
    } t_div_req;
endpackage

// File: hw/rtl/pcwh_ram.sv
// ----------------------------------------------------------------------------
// pcwh_ram: generic single-port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module pcwh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// File: hw/rtl/pcwh_div.sv
// ----------------------------------------------------------------------------
// pcwh_div: signed restoring divider
// One quotient bit per cycle, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module pcwh_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  pcwh_pkg::t_div_req           i_req,
    output logic                         o_done,
    output logic signed [pcwh_pkg::DW-1:0] o_quot
);
    localparam int SW = pcwh_pkg::SW;
    localparam int CW = pcwh_pkg::CW;
    localparam int KW = $clog2(SW + 1);

    logic [SW-1:0] r_q, n_q;
    logic [CW:0]   r_rem, n_rem;
    logic [CW-1:0] r_den;
    logic          r_neg, r_busy, n_busy;
    logic [KW-1:0] r_k, n_k;
    logic [CW:0]   trial;

    always_comb begin
        n_q = r_q;
        n_rem = r_rem;
        n_busy = r_busy;
        n_k = r_k;
        trial = {r_rem[CW-1:0], r_q[SW-1]};
        if (r_busy) begin
            n_q = {r_q[SW-2:0], 1'b0};
            if (trial >= {1'b0, r_den}) begin
                n_rem = trial - {1'b0, r_den};
                n_q[0] = 1'b1;
            end else begin
                n_rem = trial;
            end
            n_k = r_k - 1'b1;
            if (r_k == KW'(1)) n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= r_busy && !n_busy;
            r_busy <= i_start ? 1'b1 : n_busy;
        end
        if (i_start) begin
            r_q <= i_req.sum[SW-1] ? SW'(-i_req.sum) : SW'(i_req.sum);
            r_neg <= i_req.sum[SW-1];
            r_den <= i_req.cnt;
            r_rem <= '0;
            r_k <= KW'(SW);
        end else begin
            r_q <= n_q;
            r_rem <= n_rem;
            r_k <= n_k;
        end
    end

    assign o_quot = r_neg ? -($signed(r_q[pcwh_pkg::DW-1:0]))
                          : $signed(r_q[pcwh_pkg::DW-1:0]);
endmodule

// File: hw/rtl/point_cloud_window_height_top.sv
// ----------------------------------------------------------------------------
// point_cloud_window_height_top: point store with window average height
// Point store in one RAM, user-sorted by x; queries bisect, walk, divide if found.
// ----------------------------------------------------------------------------
// Clear and append give a result the cycle after the item is taken; op code 3 too.
// A query bisects the store twice over the RAM port, for the lower and upper x
// bound, walks the entries between them, runs the divider when anything is found
// and then posts the result.
// One item at a time; the next item is taken once the result register frees.
// Synchronous active-low reset empties the store; RAM contents are not cleared.
module point_cloud_window_height_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [1:0]                          i_op,
    input  logic signed [pcwh_pkg::DW-1:0]      i_pos_x,
    input  logic signed [pcwh_pkg::DW-1:0]      i_pos_y,
    input  logic signed [pcwh_pkg::DW-1:0]      i_height_in,
    input  logic                                i_height_in_valid,
    input  logic [15:0]                         i_radius,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [pcwh_pkg::DW-1:0]      o_height_out,
    output logic                                o_height_found,
    output logic [pcwh_pkg::CW-1:0]             o_points_averaged,
    output logic [pcwh_pkg::CW-1:0]             o_stored_points,
    output logic                                o_load_rejected
);
    localparam int DW = pcwh_pkg::DW;
    localparam int CW = pcwh_pkg::CW;
    localparam int AW = pcwh_pkg::AW;
    localparam int MW = pcwh_pkg::MW;
    localparam int SW = pcwh_pkg::SW;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_BRD  = 3'd1;
    localparam logic [2:0] S_BCMP = 3'd2;
    localparam logic [2:0] S_WRD  = 3'd3;
    localparam logic [2:0] S_WCMP = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0] r_state;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_lo, r_n, r_first, r_i;
    logic r_pass;
    logic signed [DW+1:0] r_key, r_ylo, r_yhi, r_khi;
    logic signed [SW-1:0] r_sum;
    logic [CW-1:0] r_cnt;
    logic r_div_start;

    logic ram_we;
    logic [AW-1:0] ram_addr;
    logic [MW-1:0] ram_wdata, ram_rdata;
    logic [CW-1:0] half, mid;
    logic signed [DW+1:0] vx, vy;
    logic go_right;
    logic walk_hit;
    logic valid_set;
    logic div_done;
    logic signed [DW-1:0] quot;
    pcwh_pkg::t_div_req div_req;

    wire take = i_valid && !o_stall;

    assign o_stall = (r_state != S_IDLE) || (o_valid && i_stall);
    assign half = r_n >> 1;
    assign mid = r_lo + half;
    assign vx = (DW+2)'($signed(ram_rdata[MW-1 -: DW]));
    assign vy = (DW+2)'($signed(ram_rdata[MW-1-DW -: DW]));
    assign go_right = r_pass ? (vx <= r_key) : (vx < r_key);
    assign walk_hit = vy >= r_ylo && vy <= r_yhi && ram_rdata[0];
    assign valid_set = (take && (i_op != pcwh_pkg::OP_QUERY)) ||
                       ((r_state == S_OUT) && (!o_valid || !i_stall));

    always_comb begin
        ram_we = take && (i_op == pcwh_pkg::OP_APPEND) &&
                 (r_count < CW'(pcwh_pkg::MAX_POINTS));
        ram_wdata = {i_pos_x, i_pos_y, i_height_in, i_height_in_valid};
        if (ram_we) ram_addr = r_count[AW-1:0];
        else if (r_state == S_BRD) ram_addr = mid[AW-1:0];
        else ram_addr = r_i[AW-1:0];
    end

    assign div_req.sum = r_sum;
    assign div_req.cnt = r_cnt;

    pcwh_ram #(.WIDTH(MW), .DEPTH(pcwh_pkg::MAX_POINTS)) u_ram (
        .i_clk(i_clk), .i_we(ram_we), .i_addr(ram_addr),
        .i_wdata(ram_wdata), .o_rdata(ram_rdata)
    );

    pcwh_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_div_start),
        .i_req(div_req), .o_done(div_done), .o_quot(quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            o_valid <= 1'b0;
            r_div_start <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            if (valid_set) o_valid <= 1'b1;
            else if (o_valid && !i_stall) o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (take) begin
                        o_height_out <= '0;
                        o_height_found <= 1'b0;
                        o_points_averaged <= '0;
                        o_load_rejected <= 1'b0;
                        o_stored_points <= r_count;
                        r_key <= (DW+2)'(i_pos_x) - (DW+2)'(i_radius);
                        r_khi <= (DW+2)'(i_pos_x) + (DW+2)'(i_radius);
                        r_ylo <= (DW+2)'(i_pos_y) - (DW+2)'(i_radius);
                        r_yhi <= (DW+2)'(i_pos_y) + (DW+2)'(i_radius);
                        r_lo <= '0;
                        r_n <= r_count;
                        r_pass <= 1'b0;
                        r_sum <= '0;
                        r_cnt <= '0;
                        if (i_op == pcwh_pkg::OP_QUERY) begin
                            r_state <= S_BRD;
                        end else begin
                            if (i_op == pcwh_pkg::OP_CLEAR) begin
                                r_count <= '0;
                                o_stored_points <= '0;
                            end else if (i_op == pcwh_pkg::OP_APPEND) begin
                                if (ram_we) begin
                                    r_count <= r_count + 1'b1;
                                    o_stored_points <= r_count + 1'b1;
                                end else begin
                                    o_load_rejected <= 1'b1;
                                end
                            end
                        end
                    end
                end
                S_BRD: begin
                    if (r_n == '0) begin
                        if (!r_pass) begin
                            r_first <= r_lo;
                            r_i <= r_lo;
                            r_pass <= 1'b1;
                            r_key <= r_khi;
                            r_lo <= '0;
                            r_n <= r_count;
                        end else begin
                            // r_lo now holds the upper bound
                            r_state <= (r_first < r_lo) ? S_WRD : S_OUT;
                        end
                    end else begin
                        r_state <= S_BCMP;
                    end
                end
                S_BCMP: begin
                    if (go_right) begin
                        r_lo <= mid + 1'b1;
                        r_n <= r_n - half - 1'b1;
                    end else begin
                        r_n <= half;
                    end
                    r_state <= S_BRD;
                end
                S_WRD: r_state <= S_WCMP;
                S_WCMP: begin
                    if (walk_hit) begin
                        r_sum <= r_sum + SW'($signed(ram_rdata[DW:1]));
                        r_cnt <= r_cnt + 1'b1;
                    end
                    r_i <= r_i + 1'b1;
                    if (r_i + 1'b1 < r_lo) begin
                        r_state <= S_WRD;
                    end else begin
                        r_state <= S_DIV;
                        // start the divider only when something was found
                        r_div_start <= (r_cnt != '0) || walk_hit;
                    end
                end
                S_DIV: begin
                    if (r_cnt == '0) begin
                        r_state <= S_OUT;
                    end else if (div_done) begin
                        o_height_out <= quot;
                        o_height_found <= 1'b1;
                        o_points_averaged <= r_cnt;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!o_valid || !i_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(pcwh_pkg::MAX_POINTS))
        else $error("point count beyond store size");
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall)
        else $error("item taken during query");
    a_reject_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_op == pcwh_pkg::OP_APPEND) |=> (o_load_rejected == $past(r_count ==
        CW'(pcwh_pkg::MAX_POINTS))))
        else $error("reject flag disagrees with fill");
    a_found_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_height_found == (o_points_averaged != '0)))
        else $error("found flag disagrees with count");
`endif
endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for point_cloud_window_height_top
// Loads point clouds, runs radius height queries and checks every result
// against a behavioral store model kept inside the bench.
// ----------------------------------------------------------------------------
module testbench;
    localparam int DW         = pcwh_pkg::DW;
    localparam int CW         = pcwh_pkg::CW;
    localparam int IDLE_PCT   = 11;
    localparam longint LIMIT  = 4000000;
    localparam int FAST_LEN   = 400;
    localparam int HOLD_LEN   = 300;

    typedef struct {
        logic signed [DW-1:0] height;
        logic                 found;
        logic [CW-1:0]        averaged;
        logic [CW-1:0]        stored;
        logic                 rejected;
    } t_answer;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic [1:0]           i_op;
    logic signed [DW-1:0] i_pos_x;
    logic signed [DW-1:0] i_pos_y;
    logic signed [DW-1:0] i_height_in;
    logic                 i_height_in_valid;
    logic [15:0]          i_radius;
    logic                 o_valid;
    logic                 i_stall;
    logic signed [DW-1:0] o_height_out;
    logic                 o_height_found;
    logic [CW-1:0]        o_points_averaged;
    logic [CW-1:0]        o_stored_points;
    logic                 o_load_rejected;

    point_cloud_window_height_top i_dut (.*);

    // bench copy of the point store
    logic signed [DW-1:0] mem_x [pcwh_pkg::MAX_POINTS];
    logic signed [DW-1:0] mem_y [pcwh_pkg::MAX_POINTS];
    logic signed [DW-1:0] mem_h [pcwh_pkg::MAX_POINTS];
    logic                 mem_hv [pcwh_pkg::MAX_POINTS];
    int                   n_points;
    int                   last_x;

    t_answer answers_due[$];
    int      mismatches;
    int      results_seen;
    int      queries_sent;
    int      queries_found;
    int      rejects_seen;
    longint  cycles;
    bit      rx_noidle;
    bit      tx_noidle;
    bit      hold_req;
    bit      hold_ack;
    int      rx_hold;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL");
            $finish;
        end
    end

    function automatic int locate_x(longint key, bit strict);
        int lo;
        int n;
        int half;
        begin
            lo = 0;
            n = n_points;
            while (n > 0) begin
                half = n / 2;
                if (strict ? (longint'(mem_x[lo + half]) <= key)
                           : (longint'(mem_x[lo + half]) < key)) begin
                    lo = lo + half + 1;
                    n = n - half - 1;
                end else begin
                    n = half;
                end
            end
            return lo;
        end
    endfunction

    function automatic t_answer apply_item(logic [1:0] op, logic signed [DW-1:0] px,
                                           logic signed [DW-1:0] py,
                                           logic signed [DW-1:0] h, logic hv,
                                           logic [15:0] r);
        t_answer a;
        int first;
        int last;
        longint sum;
        longint cnt;
        longint avg;
        begin
            a = '{default: 0};
            if (op == pcwh_pkg::OP_CLEAR) begin
                n_points = 0;
            end else if (op == pcwh_pkg::OP_APPEND) begin
                if (n_points < pcwh_pkg::MAX_POINTS) begin
                    mem_x[n_points] = px;
                    mem_y[n_points] = py;
                    mem_h[n_points] = h;
                    mem_hv[n_points] = hv;
                    n_points++;
                end else begin
                    a.rejected = 1;
                end
            end else if (op == pcwh_pkg::OP_QUERY) begin
                first = locate_x(longint'(px) - longint'(r), 0);
                last = locate_x(longint'(px) + longint'(r), 1);
                sum = 0;
                cnt = 0;
                for (int i = first; i < last; i++) begin
                    if (longint'(mem_y[i]) >= longint'(py) - longint'(r)
                        && longint'(mem_y[i]) <= longint'(py) + longint'(r)
                        && mem_hv[i]) begin
                        sum += mem_h[i];
                        cnt++;
                    end
                end
                if (cnt > 0) begin
                    avg = sum / cnt;
                    a.height = avg[DW-1:0];
                    a.found = 1;
                    a.averaged = cnt[CW-1:0];
                end
            end
            a.stored = n_points[CW-1:0];
            return a;
        end
    endfunction

    task automatic send_item(logic [1:0] op, logic signed [DW-1:0] px,
                             logic signed [DW-1:0] py, logic signed [DW-1:0] h,
                             logic hv, logic [15:0] r);
        begin
            while (!tx_noidle && $urandom_range(99) < IDLE_PCT) begin
                i_valid <= 0;
                @(posedge i_clk);
            end
            i_valid <= 1;
            i_op <= op;
            i_pos_x <= px;
            i_pos_y <= py;
            i_height_in <= h;
            i_height_in_valid <= hv;
            i_radius <= r;
            @(posedge i_clk);
            while (o_stall) @(posedge i_clk);
            answers_due.push_back(apply_item(op, px, py, h, hv, r));
            if (op == pcwh_pkg::OP_QUERY) queries_sent++;
        end
    endtask

    task automatic drain;
        begin
            i_valid <= 0;
            while (answers_due.size() > 0) @(posedge i_clk);
            repeat (10) @(posedge i_clk);
        end
    endtask

    // append a point with x no smaller than the last one, keeping order
    task automatic append_sorted(int step_max, int spread);
        begin
            last_x = last_x + $urandom_range(step_max);
            if (last_x > 8388607) last_x = 8388607;
            send_item(pcwh_pkg::OP_APPEND, DW'(last_x),
                      DW'($urandom_range(2 * spread) - spread),
                      DW'($urandom), $urandom_range(99) < 85, 16'($urandom));
        end
    endtask

    task automatic query_near(int spread);
        begin
            send_item(pcwh_pkg::OP_QUERY, DW'(last_x - $urandom_range(spread)),
                      DW'($urandom_range(2 * spread) - spread), DW'($urandom),
                      1'($urandom),
                      16'($urandom_range(99) < 80 ? $urandom_range(spread) : $urandom));
        end
    endtask

    task automatic test_directed;
        begin
            send_item(pcwh_pkg::OP_QUERY, 0, 0, 0, 0, 16'hFFFF);
            send_item(pcwh_pkg::OP_APPEND, -8388608, -8388608, -8388608, 1, 0);
            send_item(pcwh_pkg::OP_APPEND, -8388608, 8388607, 8388607, 1, 16'hFFFF);
            send_item(pcwh_pkg::OP_APPEND, 0, 0, -5, 1, 0);
            send_item(pcwh_pkg::OP_APPEND, 0, 3, 100, 0, 0);
            send_item(pcwh_pkg::OP_APPEND, 8388607, 8388607, 8388607, 1, 0);
            send_item(pcwh_pkg::OP_APPEND, 8388607, -8388608, -8388608, 1, 0);
            send_item(pcwh_pkg::OP_QUERY, -8388608, -8388608, 0, 0, 0);
            send_item(pcwh_pkg::OP_QUERY, -8388608, 0, 0, 0, 16'hFFFF);
            send_item(pcwh_pkg::OP_QUERY, 0, 0, 0, 0, 0);
            send_item(pcwh_pkg::OP_QUERY, 0, 0, 0, 0, 3);
            send_item(pcwh_pkg::OP_QUERY, 8388607, 8388607, 0, 0, 16'hFFFF);
            send_item(pcwh_pkg::OP_QUERY, 8388607, 0, 0, 0, 0);
            send_item(pcwh_pkg::OP_QUERY, 1000, 1000, 0, 0, 5);
            send_item(pcwh_pkg::OP_UNUSED, 7, 7, 7, 1, 7);
            // unsorted load: bisection over a store that is out of x order
            send_item(pcwh_pkg::OP_APPEND, 50, 0, 9, 1, 0);
            send_item(pcwh_pkg::OP_APPEND, -50, 0, -7, 1, 0);
            send_item(pcwh_pkg::OP_QUERY, 0, 0, 0, 0, 100);
            send_item(pcwh_pkg::OP_QUERY, -50, 0, 0, 0, 0);
            send_item(pcwh_pkg::OP_CLEAR, 0, 0, 0, 0, 0);
            send_item(pcwh_pkg::OP_QUERY, 0, 0, 0, 0, 16'hFFFF);
            drain();
        end
    endtask

    task automatic test_random_clouds(int items);
        int left;
        int spread;
        begin
            left = items;
            while (left > 0) begin
                send_item(pcwh_pkg::OP_CLEAR, DW'($urandom), DW'($urandom), DW'($urandom),
                          1'($urandom), 16'($urandom));
                left--;
                spread = $urandom_range(3) == 0 ? 8000000 : $urandom_range(20, 2000);
                last_x = -8388608 + $urandom_range(16000000);
                for (int k = $urandom_range(2, 25); k > 0 && left > 0; k--, left--) begin
                    case ($urandom_range(9))
                        0, 1, 2:  query_near(spread);
                        3:        send_item(2'($urandom_range(3)), DW'($urandom),
                                            DW'($urandom), DW'($urandom),
                                            1'($urandom), 16'($urandom));
                        default:  append_sorted(spread / 4 + 1, spread);
                    endcase
                end
            end
            drain();
        end
    endtask

    task automatic test_backpressure;
        begin
            hold_req = !hold_req;
            for (int i = 0; i < 12; i++) append_sorted(50, 100);
            for (int i = 0; i < 6; i++) query_near(100);
            drain();
        end
    endtask

    // result side: random stall, plus a long hold when requested
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1;
            rx_hold <= 0;
            hold_ack <= hold_req;
        end else if (hold_req != hold_ack) begin
            hold_ack <= hold_req;
            rx_hold <= HOLD_LEN;
            i_stall <= 1;
        end else if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            i_stall <= 1;
        end else begin
            i_stall <= !rx_noidle && ($urandom_range(99) < IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        t_answer e;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (answers_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result at cycle %0d", cycles);
            end else begin
                e = answers_due.pop_front();
                if (o_load_rejected) rejects_seen++;
                if (o_height_found) queries_found++;
                if (o_height_out !== e.height || o_height_found !== e.found
                    || o_points_averaged !== e.averaged || o_stored_points !== e.stored
                    || o_load_rejected !== e.rejected) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch %0d: exp h=%0d f=%0d n=%0d s=%0d r=%0d got h=%0d f=%0d n=%0d s=%0d r=%0d",
                                 results_seen, e.height, e.found, e.averaged, e.stored,
                                 e.rejected, o_height_out, o_height_found,
                                 o_points_averaged, o_stored_points, o_load_rejected);
                end
            end
        end
    end

    initial begin
        cycles = 0;
        mismatches = 0;
        results_seen = 0;
        queries_sent = 0;
        queries_found = 0;
        rejects_seen = 0;
        n_points = 0;
        last_x = 0;
        rx_noidle = 0;
        tx_noidle = 0;
        hold_req = 0;
        i_rst_n = 0;
        i_valid = 0;
        i_op = pcwh_pkg::OP_CLEAR;
        i_pos_x = 0;
        i_pos_y = 0;
        i_height_in = 0;
        i_height_in_valid = 0;
        i_radius = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        test_directed();
        tx_noidle = 1;
        rx_noidle = 1;
        test_random_clouds(FAST_LEN / 4);
        tx_noidle = 0;
        rx_noidle = 0;
        test_random_clouds(1030 - FAST_LEN / 4);
        test_backpressure();
        $display("covered %0d results: edge loads, unsorted clouds, random clouds and a held",
                 results_seen);
        $display("receiver; %0d queries (%0d found), %0d rejected loads",
                 queries_sent, queries_found, rejects_seen);
        if (mismatches == 0 && answers_due.size() == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, answers_due.size());
            $display("FAIL");
        end
        $finish;
    end
endmodule
